### rtl/msadpcm_pkg.sv
// shared types, codes and tables of the ms adpcm block decoder
`default_nettype none

package msadpcm_pkg;

	localparam int CHANNELS     = 2;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] OP_PRED   = 3'd0;
	localparam logic [2:0] OP_DELTA  = 3'd1;
	localparam logic [2:0] OP_NEWEST = 3'd2;
	localparam logic [2:0] OP_OLDER  = 3'd3;
	localparam logic [2:0] OP_DATA   = 3'd4;

	localparam logic [0:0] CFG_CHANNEL_COUNT = 1'd0;
	localparam logic [0:0] CFG_BLOCK_ALIGN   = 1'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} src_item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               channel;
		logic               last;
		logic               block_end;
	} pcm_item_t;

	typedef struct packed {
		logic [2:0]  op;
		logic        ch;
		logic [15:0] value;
		logic        emit;
		logic        bend;
		logic        stereo;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       ch;
		logic       push;
	} hdr_class_t;

	function automatic hdr_class_t hdr_classify(input logic stereo, input logic [3:0] pos);
		hdr_class_t c;
		c = '{op: OP_PRED, ch: 1'b0, push: 1'b1};
		if (!stereo) begin
			case (pos)
				4'd0: c = '{op: OP_PRED,   ch: 1'b0, push: 1'b1};
				4'd1: c = '{op: OP_DELTA,  ch: 1'b0, push: 1'b0};
				4'd2: c = '{op: OP_DELTA,  ch: 1'b0, push: 1'b1};
				4'd3: c = '{op: OP_NEWEST, ch: 1'b0, push: 1'b0};
				4'd4: c = '{op: OP_NEWEST, ch: 1'b0, push: 1'b1};
				4'd5: c = '{op: OP_OLDER,  ch: 1'b0, push: 1'b0};
				4'd6: c = '{op: OP_OLDER,  ch: 1'b0, push: 1'b1};
				default: c = '{op: OP_PRED, ch: 1'b0, push: 1'b0};
			endcase
		end else begin
			case (pos)
				4'd0:  c = '{op: OP_PRED,   ch: 1'b0, push: 1'b1};
				4'd1:  c = '{op: OP_PRED,   ch: 1'b1, push: 1'b1};
				4'd2:  c = '{op: OP_DELTA,  ch: 1'b0, push: 1'b0};
				4'd3:  c = '{op: OP_DELTA,  ch: 1'b0, push: 1'b1};
				4'd4:  c = '{op: OP_DELTA,  ch: 1'b1, push: 1'b0};
				4'd5:  c = '{op: OP_DELTA,  ch: 1'b1, push: 1'b1};
				4'd6:  c = '{op: OP_NEWEST, ch: 1'b0, push: 1'b0};
				4'd7:  c = '{op: OP_NEWEST, ch: 1'b0, push: 1'b1};
				4'd8:  c = '{op: OP_NEWEST, ch: 1'b1, push: 1'b0};
				4'd9:  c = '{op: OP_NEWEST, ch: 1'b1, push: 1'b1};
				4'd10: c = '{op: OP_OLDER,  ch: 1'b0, push: 1'b0};
				4'd11: c = '{op: OP_OLDER,  ch: 1'b0, push: 1'b1};
				4'd12: c = '{op: OP_OLDER,  ch: 1'b1, push: 1'b0};
				4'd13: c = '{op: OP_OLDER,  ch: 1'b1, push: 1'b1};
				default: c = '{op: OP_PRED, ch: 1'b0, push: 1'b0};
			endcase
		end
		return c;
	endfunction

	function automatic logic signed [10:0] coef_a(input logic [2:0] p);
		case (p)
			3'd0: return 11'sd256;
			3'd1: return 11'sd512;
			3'd2: return 11'sd0;
			3'd3: return 11'sd192;
			3'd4: return 11'sd240;
			3'd5: return 11'sd460;
			default: return 11'sd392;
		endcase
	endfunction

	function automatic logic signed [9:0] coef_b(input logic [2:0] p);
		case (p)
			3'd0: return 10'sd0;
			3'd1: return -10'sd256;
			3'd2: return 10'sd0;
			3'd3: return 10'sd64;
			3'd4: return 10'sd0;
			3'd5: return -10'sd208;
			default: return -10'sd232;
		endcase
	endfunction

	function automatic logic [9:0] adapt_gain(input logic [3:0] nib);
		case (nib)
			4'd4, 4'd12: return 10'd307;
			4'd5, 4'd11: return 10'd409;
			4'd6, 4'd10: return 10'd512;
			4'd7, 4'd9:  return 10'd614;
			4'd8:        return 10'd768;
			default:     return 10'd230;
		endcase
	endfunction

endpackage

`default_nettype wire

### rtl/msadpcm_front.sv
// front end: block position tracking and byte classification into commands
`default_nettype none

module msadpcm_front
	import msadpcm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire src_item_t   item,
	input  wire logic [1:0]  channel_count,
	input  wire logic [15:0] block_align,
	output logic             push,
	output cmd_t             cmd
);

	logic [15:0] pos_q;
	logic [7:0]  low_q;
	logic        stereo;
	logic [3:0]  hdr;
	logic [15:0] blk_len;
	logic [15:0] pos;
	logic        bend;
	logic        is_hdr;
	hdr_class_t  cls;
	logic [2:0]  pclamp;

	assign stereo  = channel_count[1];
	assign hdr     = stereo ? 4'd14 : 4'd7;
	assign blk_len = (block_align < {12'd0, hdr}) ? {12'd0, hdr} : block_align;
	assign pos     = item.restart ? 16'd0 : pos_q;
	assign bend    = pos >= (blk_len - 16'd1);
	assign is_hdr  = pos < {12'd0, hdr};
	assign cls     = hdr_classify(stereo, pos[3:0]);
	assign pclamp  = (item.data_byte > 8'd6) ? 3'd6 : item.data_byte[2:0];

	always_comb begin
		cmd.ch     = is_hdr ? cls.ch : 1'b0;
		cmd.emit   = is_hdr && (pos == {12'd0, hdr - 4'd1});
		cmd.bend   = bend;
		cmd.stereo = stereo;
		if (!is_hdr) begin
			cmd.op    = OP_DATA;
			cmd.value = {8'd0, item.data_byte};
		end else if (cls.op == OP_PRED) begin
			cmd.op    = OP_PRED;
			cmd.value = {13'd0, pclamp};
		end else begin
			cmd.op    = cls.op;
			cmd.value = {item.data_byte, low_q};
		end
	end

	assign push = accept && (!is_hdr || cls.push);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 16'd0;
			low_q <= 8'd0;
		end else if (accept) begin
			pos_q <= bend ? 16'd0 : pos + 16'd1;
			if (is_hdr && !cls.push) begin
				low_q <= item.data_byte;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/msadpcm_queue.sv
// short command queue between front and back
`default_nettype none

module msadpcm_queue
	import msadpcm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output logic      full,
	output logic      head_valid,
	output cmd_t      head_cmd
);

	cmd_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	assign full       = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/msadpcm_back.sv
// back end: channel state, nibble decode, header emission and output register
`default_nettype none

module msadpcm_back
	import msadpcm_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  wire cmd_t  head_cmd,
	output logic       pop,
	output logic       pcm_valid,
	input  wire logic  pcm_stall,
	output pcm_item_t  pcm_item
);

	logic [2:0]         pred_q   [CHANNELS];
	logic signed [15:0] delta_q  [CHANNELS];
	logic signed [15:0] newest_q [CHANNELS];
	logic signed [15:0] older_q  [CHANNELS];
	logic [2:0]         step_q;
	logic               out_valid_q;
	pcm_item_t          out_q;

	logic               adv;
	logic               go;
	logic               dch;
	logic [3:0]         nib;
	logic signed [3:0]  snib;
	logic signed [10:0] ca;
	logic signed [9:0]  cb;
	logic signed [26:0] prod_a;
	logic signed [25:0] prod_b;
	logic signed [27:0] psum;
	logic signed [19:0] pdiv;
	logic signed [19:0] sd;
	logic signed [20:0] ptot;
	logic signed [15:0] pclamp;
	logic signed [10:0] gain;
	logic signed [26:0] aprod;
	logic signed [18:0] adiv;
	logic signed [15:0] dnew;
	logic [1:0]         e;
	logic               ech;
	logic               enew;
	logic               elast;
	logic               produce;
	logic [2:0]         step_d;
	pcm_item_t          out_d;
	logic               hdr_write;
	logic               data_write;

	assign adv = !out_valid_q || !pcm_stall;
	assign go  = head_valid && adv;

	assign dch  = step_q[0] ? head_cmd.stereo : 1'b0;
	assign nib  = step_q[0] ? head_cmd.value[3:0] : head_cmd.value[7:4];
	assign snib = nib;
	assign ca   = coef_a(pred_q[dch]);
	assign cb   = coef_b(pred_q[dch]);

	assign prod_a = 27'(newest_q[dch]) * 27'(ca);
	assign prod_b = 26'(older_q[dch]) * 26'(cb);
	assign psum   = 28'(prod_a) + 28'(prod_b);
	assign pdiv   = psum[27:8] + {19'd0, psum[27] && (psum[7:0] != 8'd0)};
	assign sd     = 20'(snib) * 20'(delta_q[dch]);
	assign ptot   = 21'(pdiv) + 21'(sd);

	always_comb begin
		if (ptot > 21'sd32767) begin
			pclamp = 16'sd32767;
		end else if (ptot < -21'sd32768) begin
			pclamp = -16'sd32768;
		end else begin
			pclamp = ptot[15:0];
		end
	end

	assign gain  = {1'b0, adapt_gain(nib)};
	assign aprod = 27'(gain) * 27'(delta_q[dch]);
	assign adiv  = aprod[26:8] + {18'd0, aprod[26] && (aprod[7:0] != 8'd0)};

	always_comb begin
		if (adiv < 19'sd16) begin
			dnew = 16'sd16;
		end else if (adiv > 19'sd32767) begin
			dnew = 16'sd32767;
		end else begin
			dnew = adiv[15:0];
		end
	end

	assign e     = 2'(step_q - 3'd1);
	assign ech   = head_cmd.stereo ? e[0] : 1'b0;
	assign enew  = head_cmd.stereo ? e[1] : e[0];
	assign elast = e == (head_cmd.stereo ? 2'd3 : 2'd1);

	always_comb begin
		pop        = 1'b0;
		produce    = 1'b0;
		step_d     = step_q;
		hdr_write  = 1'b0;
		data_write = 1'b0;
		out_d      = '{sample: pclamp, channel: dch, last: 1'b0, block_end: 1'b0};
		if (go) begin
			if (head_cmd.op == OP_DATA) begin
				data_write      = 1'b1;
				produce         = 1'b1;
				out_d.last      = step_q[0];
				out_d.block_end = step_q[0] && head_cmd.bend;
				if (step_q[0]) begin
					pop    = 1'b1;
					step_d = 3'd0;
				end else begin
					step_d = 3'd1;
				end
			end else if (step_q == 3'd0) begin
				hdr_write = 1'b1;
				if (head_cmd.emit) begin
					step_d = 3'd1;
				end else begin
					pop = 1'b1;
				end
			end else begin
				produce         = 1'b1;
				out_d.sample    = enew ? newest_q[ech] : older_q[ech];
				out_d.channel   = ech;
				out_d.last      = elast;
				out_d.block_end = elast && head_cmd.bend;
				if (elast) begin
					pop    = 1'b1;
					step_d = 3'd0;
				end else begin
					step_d = step_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pred_q[c]   <= 3'd0;
				delta_q[c]  <= 16'sd0;
				newest_q[c] <= 16'sd0;
				older_q[c]  <= 16'sd0;
			end
			step_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (adv) begin
				out_valid_q <= produce;
			end
			if (data_write) begin
				older_q[dch]  <= newest_q[dch];
				newest_q[dch] <= pclamp;
				delta_q[dch]  <= dnew;
			end
			if (hdr_write) begin
				case (head_cmd.op)
					OP_PRED:   pred_q[head_cmd.ch]   <= head_cmd.value[2:0];
					OP_DELTA:  delta_q[head_cmd.ch]  <= head_cmd.value;
					OP_NEWEST: newest_q[head_cmd.ch] <= head_cmd.value;
					OP_OLDER:  older_q[head_cmd.ch]  <= head_cmd.value;
					default:   ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			out_q <= out_d;
		end
	end

	assign pcm_valid = out_valid_q;
	assign pcm_item  = out_q;

endmodule

`default_nettype wire

### rtl/ms_adpcm_block_decoder.sv
// ms adpcm block decoder top level: config registers, front, queue, back
//
//   port       dir  flow         content
//   src_*      in   valid/stall  one block byte and restart flag
//   pcm_*      out  valid/stall  one pcm sample with channel, last, block_end
//   cfg_*      in   valid/ready  register index and write data
//
// a data byte is decoded in the back end one nibble at a time, both through the
// shared predictor and adaption multipliers; the last header byte writes its field
// and then emits each header sample, other header bytes write one field or none
// reset clears position, channel state and queue; registers go to 1 and 256
// a four entry command queue lets bytes be taken while samples are stalled
`default_nettype none

module ms_adpcm_block_decoder
	import msadpcm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire src_item_t   src_item,
	output logic             pcm_valid,
	input  wire logic        pcm_stall,
	output pcm_item_t        pcm_item,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic [1:0]  chan_count_q;
	logic [15:0] block_align_q;
	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_valid;
	cmd_t        f_cmd;
	cmd_t        q_cmd;

	assign cfg_ready = 1'b1;
	assign src_stall = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q  <= 2'd1;
			block_align_q <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHANNEL_COUNT: chan_count_q  <= cfg_data[1:0];
				CFG_BLOCK_ALIGN:   block_align_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	msadpcm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (src_valid && !src_stall),
		.item          (src_item),
		.channel_count (chan_count_q),
		.block_align   (block_align_q),
		.push          (q_push),
		.cmd           (f_cmd)
	);

	msadpcm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (f_cmd),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head_cmd   (q_cmd)
	);

	msadpcm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_cmd   (q_cmd),
		.pop        (q_pop),
		.pcm_valid  (pcm_valid),
		.pcm_stall  (pcm_stall),
		.pcm_item   (pcm_item)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command pushed into full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	a_bend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pcm_valid && pcm_item.block_end) |-> pcm_item.last)
		else $error("block end on a sample that is not last of its byte");
`endif

endmodule

`default_nettype wire

### tb/adpcm_sample_checker.sv
// checker for the ms adpcm block decoder: byte level prediction and sample comparison
`timescale 1ns / 1ps

module adpcm_sample_checker
	import msadpcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	input  logic        src_stall,
	input  src_item_t   src_item,
	input  logic        pcm_valid,
	input  logic        pcm_stall,
	input  pcm_item_t   pcm_item,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	int weight_new [7] = '{256, 512, 0, 192, 240, 460, 392};
	int weight_old [7] = '{0, -256, 0, 64, 0, -208, -232};
	int step_gain [16] = '{230, 230, 230, 230, 307, 409, 512, 614,
		768, 614, 512, 409, 307, 230, 230, 230};

	logic [1:0]  chan_cfg;
	logic [15:0] align_cfg;
	logic [15:0] blk_pos;
	logic [2:0]  coef_sel [2];
	shortint     step_size [2];
	shortint     hist_new [2];
	shortint     hist_old [2];
	logic [7:0]  word_lo;

	pcm_item_t expected_pcm [$];

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic void expect_sample(input shortint s, input logic ch,
			input logic lst, input logic be);
		pcm_item_t e;
		e.sample = s;
		e.channel = ch;
		e.last = lst;
		e.block_end = be;
		expected_pcm = {expected_pcm, e};
	endfunction

	function automatic shortint decode_sample(input int c, input logic [3:0] nib);
		int sn, est, d;
		sn = nib[3] ? int'(nib) - 16 : int'(nib);
		est = (int'(hist_new[c]) * weight_new[coef_sel[c]]
			+ int'(hist_old[c]) * weight_old[coef_sel[c]]) / 256
			+ sn * int'(step_size[c]);
		if (est > 32767) est = 32767;
		if (est < -32768) est = -32768;
		hist_old[c] = hist_new[c];
		hist_new[c] = shortint'(est);
		d = (step_gain[nib] * int'(step_size[c])) / 256;
		if (d < 16) d = 16;
		if (d > 32767) d = 32767;
		step_size[c] = shortint'(d);
		return shortint'(est);
	endfunction

	task automatic accept_byte(input src_item_t it);
		int nch, hdr, blen, p, r, fld, wthn, c;
		logic bend;
		shortint w, s0, s1;
		nch = (chan_cfg == 0) ? 1 : ((chan_cfg > 2) ? 2 : int'(chan_cfg));
		hdr = 7 * nch;
		blen = (int'(align_cfg) < hdr) ? hdr : int'(align_cfg);
		if (it.restart) blk_pos = '0;
		p = int'(blk_pos);
		bend = (p >= blen - 1);
		if (p < hdr) begin
			if (p < nch) begin
				coef_sel[p] = (it.data_byte > 6) ? 3'd6 : it.data_byte[2:0];
			end else begin
				r = p - nch;
				fld = r / (2 * nch);
				wthn = r % (2 * nch);
				c = wthn >> 1;
				if (wthn % 2 == 0) begin
					word_lo = it.data_byte;
				end else begin
					w = {it.data_byte, word_lo};
					case (fld)
						0: step_size[c] = w;
						1: hist_new[c] = w;
						default: hist_old[c] = w;
					endcase
				end
			end
			if (p == hdr - 1) begin
				for (int k = 0; k < nch; k++) expect_sample(hist_old[k], k[0], 1'b0, 1'b0);
				for (int k = 0; k < nch; k++)
					expect_sample(hist_new[k], k[0], k == nch - 1, (k == nch - 1) && bend);
			end
		end else begin
			s0 = decode_sample(0, it.data_byte[7:4]);
			expect_sample(s0, 1'b0, 1'b0, 1'b0);
			s1 = decode_sample(nch - 1, it.data_byte[3:0]);
			expect_sample(s1, nch == 2, 1'b1, bend);
		end
		blk_pos = bend ? 16'd0 : blk_pos + 16'd1;
	endtask

	task automatic check_sample(input pcm_item_t got);
		pcm_item_t e;
		if (expected_pcm.size() == 0) begin
			flag_mismatch($sformatf("unexpected sample %0d ch %0d", got.sample, got.channel));
		end else begin
			e = expected_pcm.pop_front();
			if (got.sample !== e.sample)
				flag_mismatch($sformatf("sample %0d, want %0d", got.sample, e.sample));
			if (got.channel !== e.channel)
				flag_mismatch($sformatf("channel %0d, want %0d", got.channel, e.channel));
			if (got.last !== e.last)
				flag_mismatch($sformatf("last %0d, want %0d", got.last, e.last));
			if (got.block_end !== e.block_end)
				flag_mismatch($sformatf("block_end %0d, want %0d", got.block_end, e.block_end));
		end
	endtask

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cfg = 2'd1;
			align_cfg = 16'd256;
			blk_pos = '0;
			word_lo = '0;
			for (int k = 0; k < 2; k++) begin
				coef_sel[k] = '0;
				step_size[k] = 0;
				hist_new[k] = 0;
				hist_old[k] = 0;
			end
			expected_pcm.delete();
		end else begin
			if (pcm_valid && !pcm_stall) check_sample(pcm_item);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CHANNEL_COUNT) chan_cfg = cfg_data[1:0];
				else if (cfg_index == CFG_BLOCK_ALIGN) align_cfg = cfg_data;
			end
			if (src_valid && !src_stall) accept_byte(src_item);
		end
		outstanding = expected_pcm.size();
	end

endmodule

### tb/testbench.sv
// testbench top: clock, reset, byte stream stimulus and verdict for the ms adpcm decoder
`timescale 1ns / 1ps

module testbench;
	import msadpcm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	src_item_t   src_item = '0;
	logic        pcm_valid;
	logic        pcm_stall = 1'b0;
	pcm_item_t   pcm_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = CFG_CHANNEL_COUNT;
	logic [15:0] cfg_data = '0;

	int          mismatches;
	int          outstanding;
	int          cycle_count = 0;
	int          stall_left = 0;
	bit          quiet = 1'b0;

	logic [1:0]  cur_count = 2'd1;
	logic [15:0] cur_align = 16'd256;
	int          stream_pos = 0;
	logic [7:0]  upper_byte = '0;

	ms_adpcm_block_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.pcm_valid (pcm_valid),
		.pcm_stall (pcm_stall),
		.pcm_item  (pcm_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	adpcm_sample_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.src_item    (src_item),
		.pcm_valid   (pcm_valid),
		.pcm_stall   (pcm_stall),
		.pcm_item    (pcm_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ms_adpcm_block_decoder verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			pcm_stall = 1'b0;
		end else if (stall_left > 0) begin
			pcm_stall = 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			pcm_stall = 1'b1;
			stall_left = $urandom_range(1, 10) - 1;
		end else begin
			pcm_stall = 1'b0;
		end
	end

	function automatic int channels_now();
		return (cur_count == 0) ? 1 : ((cur_count > 2) ? 2 : int'(cur_count));
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b, input logic rs);
		int blen;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			src_valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		src_item.data_byte = b;
		src_item.restart = rs;
		src_valid = 1'b1;
		do @(posedge clk); while (src_stall);
		@(negedge clk);
		blen = (int'(cur_align) < 7 * channels_now()) ? 7 * channels_now() : int'(cur_align);
		if (rs) stream_pos = 0;
		stream_pos = (stream_pos >= blen - 1) ? 0 : stream_pos + 1;
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		if (idx == CFG_CHANNEL_COUNT) cur_count = val[1:0];
		else cur_align = val;
	endtask

	task automatic wait_idle();
		src_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (24) @(negedge clk);
	endtask

	task automatic configure(input logic [1:0] cc, input logic [15:0] ba);
		wait_idle();
		write_reg(CFG_CHANNEL_COUNT, {14'd0, cc});
		write_reg(CFG_BLOCK_ALIGN, ba);
		cfg_valid = 1'b0;
	endtask

	// mostly well-formed blocks with plausible headers, some noise and early restarts
	task automatic stream(input int n);
		int nch, hdr, p, r;
		logic [15:0] w;
		logic [7:0] b;
		logic rs;
		for (int i = 0; i < n; i++) begin
			nch = channels_now();
			hdr = 7 * nch;
			if (stream_pos == 0) rs = 1'($urandom_range(0, 1));
			else rs = ($urandom_range(0, 29) == 0);
			p = rs ? 0 : stream_pos;
			if ($urandom_range(0, 19) == 0) begin
				b = 8'($urandom);
			end else if (p < nch) begin
				if ($urandom_range(0, 4) == 0) b = 8'($urandom);
				else b = 8'($urandom_range(0, 6));
			end else if (p < hdr) begin
				r = p - nch;
				if (r % 2 == 0) begin
					if (r < 2 * nch) begin
						if ($urandom_range(0, 5) == 0) w = 16'($urandom);
						else w = 16'($urandom_range(16, 1024));
					end else begin
						if ($urandom_range(0, 1) == 0) w = 16'($urandom);
						else w = 16'($urandom_range(0, 4000) - 2000);
					end
					b = w[7:0];
					upper_byte = w[15:8];
				end else begin
					b = upper_byte;
				end
			end else begin
				b = 8'($urandom);
			end
			send_byte(b, rs);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// mono header at the extremes, then data nibbles at the extremes
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h77, 1'b0);
		send_byte(8'h88, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h08, 1'b0);

		// shrink the block below the header mid block: position past the end
		wait_idle();
		write_reg(CFG_BLOCK_ALIGN, 16'd3);
		cfg_valid = 1'b0;
		send_byte(8'h5A, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'hCC, 1'b0);
		send_byte(8'hED, 1'b0);

		configure(2'd2, 16'd15);
		stream(60);
		configure(2'd0, 16'($urandom_range(8, 40)));
		stream(60);
		configure(2'd3, 16'($urandom_range(15, 60)));
		stream(60);
		configure(2'd1, 16'hFFFF);
		stream(30);
		configure(2'd2, 16'd0);
		stream(40);
		configure(2'd2, 16'($urandom_range(20, 50)));
		stream(80);
		configure(2'd1, 16'($urandom_range(7, 30)));
		stream(50);
		quiet = 1'b1;
		stream(40);

		src_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("ms_adpcm_block_decoder verification clean");
		end else begin
			$display("ms_adpcm_block_decoder verification failed");
		end
		$finish;
	end

endmodule

### ms_adpcm_block_decoder.f
rtl/msadpcm_pkg.sv
rtl/msadpcm_front.sv
rtl/msadpcm_queue.sv
rtl/msadpcm_back.sv
rtl/ms_adpcm_block_decoder.sv
tb/adpcm_sample_checker.sv
tb/testbench.sv
